/* hw/rtl/tst_pkg.sv */
// Shared types and constants for the timer slot table.
// Holds the request opcode, result status codes and the request record.
// Depends on nothing; every other file of the block imports it.
package tst_pkg;

	// Field widths fixed by the interface.
	localparam int SLOT_W = 5;
	localparam int DATA_W = 32;

	// Default table size and the cap on results per check request.
	localparam int NUM_SLOTS_DEF = 32;
	localparam int MAX_RES = 32;

	// Request queue depth between front and back; must be a power of two.
	localparam int QUEUE_DEPTH = 2;

	// Request opcodes as carried on the func port.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHECK  = 2'd2,
		OP_REARM  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_INACTIVE = 2'd2,
		ST_NONE_DUE = 2'd3
	} status_t;

	// A classified request as it travels through the queue.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic              in_range;
		logic              stop;
		logic [DATA_W-1:0] interval;
		logic [DATA_W-1:0] deadline;
		logic [DATA_W-1:0] now;
	} req_t;

endpackage

/* hw/rtl/tst_front.sv */
// Front end of the timer slot table: decodes and classifies an incoming request.
// Produces the request record that is stored in the queue.
// Depends on tst_pkg.
module tst_front import tst_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic [1:0]        func,
	input  logic [SLOT_W-1:0] slot,
	input  logic [DATA_W-1:0] interval,
	input  logic [DATA_W-1:0] now,
	output req_t              req
);

	logic [DATA_W-1:0] iv_eff;
	op_t               op;

	// An add with a zero interval runs with an interval of one tick.
	assign op = op_t'(func);
	assign iv_eff = (op == OP_ADD && interval == '0) ? DATA_W'(1) : interval;

	// Classify the request and work out its new deadline ahead of the back end.
	always_comb begin
		req.op       = op;
		req.slot     = slot;
		req.in_range = (32'(slot) < 32'(NUM_SLOTS));
		req.stop     = (interval == '0);
		req.interval = iv_eff;
		req.deadline = now + iv_eff;
		req.now      = now;
	end

endmodule

/* hw/rtl/tst_queue.sv */
// Short request queue between the front and back ends of the timer slot table.
// Lets the front accept a request while the back end is still busy.
// Depends on tst_pkg.
module tst_queue import tst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  req_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output req_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/tst_back.sv */
// Back end of the timer slot table: slot flags, the interval/deadline memory,
// the sequencer that scans the slots, and the result register.
// Depends on tst_pkg.
module tst_back import tst_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  req_t              req,
	input  logic              req_valid,
	output logic              req_ready,
	output logic [SLOT_W-1:0] slot_res,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] due_interval,
	output logic              last,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = IDX_W + 1;
	localparam int CNT_W = $clog2(MAX_RES) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_ONE,
		S_CHECK,
		S_FIN
	} state_t;

	state_t              state_q;
	req_t                cur_q;
	logic [CW-1:0]       scan_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] pending_q;

	// Check pipeline: stage 2 evaluates the slot whose memory word was just read.
	logic                v_s2_q;
	logic                elig_s2_q;
	logic [IDX_W-1:0]    idx_s2_q;

	// Due result held back until it is known whether it is the final one.
	logic                hold_v_q;
	logic [IDX_W-1:0]    hold_slot_q;
	logic [DATA_W-1:0]   hold_iv_q;

	// Result register.
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	status_t             out_status_q;
	logic [DATA_W-1:0]   out_iv_q;
	logic                out_last_q;

	// Interval and deadline memory, one word per slot: {interval, deadline}.
	logic [2*DATA_W-1:0] slot_mem_q [NUM_SLOTS];
	logic [2*DATA_W-1:0] rd_data_q;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [2*DATA_W-1:0] mem_wdata;
	logic                rd_en;

	logic [IDX_W-1:0]    scan_idx;
	logic [IDX_W-1:0]    cur_idx;
	logic                cur_ok;
	logic                out_free;
	logic                out_load;
	logic                issue;
	logic [DATA_W-1:0]   rd_iv;
	logic [DATA_W-1:0]   rd_deadline;
	logic [DATA_W-1:0]   diff;
	logic                due;
	logic                stall;

	assign scan_idx    = scan_q[IDX_W-1:0];
	assign cur_idx     = IDX_W'(cur_q.slot);
	assign cur_ok      = cur_q.in_range && active_q[cur_idx];
	assign out_free    = !out_valid_q || out_ready;
	assign req_ready   = (state_q == S_IDLE);

	// Due test: the wrapped difference now - deadline is not negative.
	assign rd_iv       = rd_data_q[2*DATA_W-1:DATA_W];
	assign rd_deadline = rd_data_q[DATA_W-1:0];
	assign diff        = cur_q.now - rd_deadline;
	assign issue       = (scan_q < CW'(NUM_SLOTS));
	assign due         = v_s2_q && elig_s2_q && !diff[DATA_W-1];
	assign stall       = due && hold_v_q && !out_free;
	assign rd_en       = (state_q == S_CHECK) && issue && !stall;

	// The result register takes a new result in this cycle.
	always_comb begin
		case (state_q)
			S_ADD: begin
				out_load = out_free &&
					(!active_q[scan_idx] || scan_q == CW'(NUM_SLOTS - 1));
			end
			S_ONE, S_FIN: begin
				out_load = out_free;
			end
			S_CHECK: begin
				out_load = due && hold_v_q && !stall;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Memory write port: add fills the free slot, rearm rewrites the target slot.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_idx;
		mem_wdata = {cur_q.interval, cur_q.deadline};
		case (state_q)
			S_ADD: begin
				mem_we = !active_q[scan_idx] && out_free;
			end
			S_ONE: begin
				mem_waddr = cur_idx;
				mem_we    = out_free && (cur_q.op == OP_REARM) && cur_ok && !cur_q.stop;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem_q[scan_idx];
		end
	end

	// Sequencer, slot flags and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			scan_q       <= '0;
			cnt_q        <= '0;
			active_q     <= '0;
			pending_q    <= '0;
			v_s2_q       <= 1'b0;
			elig_s2_q    <= 1'b0;
			idx_s2_q     <= '0;
			hold_v_q     <= 1'b0;
			hold_slot_q  <= '0;
			hold_iv_q    <= '0;
			out_valid_q  <= 1'b0;
			out_slot_q   <= '0;
			out_status_q <= ST_OK;
			out_iv_q     <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// Take the next request from the queue.
				S_IDLE: begin
					if (req_valid) begin
						cur_q    <= req;
						scan_q   <= '0;
						cnt_q    <= '0;
						v_s2_q   <= 1'b0;
						hold_v_q <= 1'b0;
						case (req.op)
							OP_ADD:   state_q <= S_ADD;
							OP_CHECK: state_q <= S_CHECK;
							default:  state_q <= S_ONE;
						endcase
					end
				end

				// Walk the slots for the first free one.
				S_ADD: begin
					if (!active_q[scan_idx]) begin
						if (out_free) begin
							active_q[scan_idx]  <= 1'b1;
							pending_q[scan_idx] <= 1'b0;
							out_valid_q  <= 1'b1;
							out_slot_q   <= SLOT_W'(scan_idx);
							out_status_q <= ST_OK;
							out_iv_q     <= '0;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else if (scan_q == CW'(NUM_SLOTS - 1)) begin
						if (out_free) begin
							out_valid_q  <= 1'b1;
							out_slot_q   <= '0;
							out_status_q <= ST_FULL;
							out_iv_q     <= '0;
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				// Remove or rearm a single slot.
				S_ONE: begin
					if (out_free) begin
						if (cur_ok) begin
							if (cur_q.op == OP_REMOVE || cur_q.stop) begin
								active_q[cur_idx] <= 1'b0;
							end
							pending_q[cur_idx] <= 1'b0;
						end
						out_valid_q  <= 1'b1;
						out_slot_q   <= cur_q.slot;
						out_status_q <= cur_ok ? ST_OK : ST_INACTIVE;
						out_iv_q     <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				// Scan for due slots: read one slot, evaluate the one read before.
				S_CHECK: begin
					if (!stall) begin
						if (issue) begin
							v_s2_q    <= 1'b1;
							elig_s2_q <= active_q[scan_idx] && !pending_q[scan_idx];
							idx_s2_q  <= scan_idx;
							scan_q    <= scan_q + 1'b1;
						end else begin
							v_s2_q <= 1'b0;
						end
						if (due) begin
							pending_q[idx_s2_q] <= 1'b1;
							hold_v_q    <= 1'b1;
							hold_slot_q <= idx_s2_q;
							hold_iv_q   <= rd_iv;
							cnt_q       <= cnt_q + 1'b1;
							if (hold_v_q) begin
								out_valid_q  <= 1'b1;
								out_slot_q   <= SLOT_W'(hold_slot_q);
								out_status_q <= ST_OK;
								out_iv_q     <= hold_iv_q;
								out_last_q   <= 1'b0;
							end
						end
						if ((due && cnt_q == CNT_W'(MAX_RES - 1)) || (v_s2_q && !issue)) begin
							state_q <= S_FIN;
						end
					end
				end

				// Deliver the final check result, or the nothing-due answer.
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						if (hold_v_q) begin
							out_slot_q   <= SLOT_W'(hold_slot_q);
							out_status_q <= ST_OK;
							out_iv_q     <= hold_iv_q;
						end else begin
							out_slot_q   <= '0;
							out_status_q <= ST_NONE_DUE;
							out_iv_q     <= '0;
						end
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign slot_res     = out_slot_q;
	assign status       = out_status_q;
	assign due_interval = out_iv_q;
	assign last         = out_last_q;

	// A slot can only be pending while it is active.
	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~active_q) == '0)
		else $error("pending flag set on an inactive slot");

	// A check never reports more than the result cap.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("check result count above cap");

	// A slot found due is marked pending on the next cycle.
	a_due_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && due && !stall) |=> pending_q[$past(idx_s2_q)])
		else $error("due slot not marked pending");

	// A held result is never overwritten while the result register is blocked.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && stall) |=> ($stable(hold_slot_q) && $stable(hold_iv_q)))
		else $error("held due result changed during a stall");

endmodule

/* hw/rtl/timer_slot_table_top.sv */
// Timer slot table: add, remove, check and rearm of NUM_SLOTS software timers.
// One request is worked at a time. Remove and rearm update one slot and give one result;
// add scans the slots for the first free one; check scans every slot, one slot per cycle
// through the memory read port while the result register does not stall the scan.
// A two-entry request queue accepts new requests while the back end works.
// Reset clears all active and pending flags at once; timer memory needs no clearing.
module timer_slot_table_top import tst_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [SLOT_W-1:0] slot,
	input  logic [DATA_W-1:0] interval,
	input  logic [DATA_W-1:0] now,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] slot_res,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] due_interval,
	output logic              last
);

	req_t front_req;
	req_t queue_req;
	logic queue_valid;
	logic queue_ready;

	// Request decode.
	tst_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.func     (func),
		.slot     (slot),
		.interval (interval),
		.now      (now),
		.req      (front_req)
	);

	// Request queue.
	tst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_req),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_req)
	);

	// Slot table engine.
	tst_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (queue_req),
		.req_valid    (queue_valid),
		.req_ready    (queue_ready),
		.slot_res     (slot_res),
		.status       (status),
		.due_interval (due_interval),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule
